@@ rtl/tli_pkg.sv @@
// Shared types and constants for the table linear interpolator.
package tli_pkg;

    // Fixed field widths
    localparam int TimeW  = 32;
    localparam int VelW   = 32;
    localparam int IndexW = 12;
    localparam int CfgW   = 13;
    localparam int WordW  = 2 * VelW + TimeW;

    // Input kind codes
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // One table entry as stored in memory
    typedef struct packed {
        logic [VelW-1:0]  east;
        logic [VelW-1:0]  north;
        logic [TimeW-1:0] tstamp;
    } entry_t;

    // Top-level sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ARITH,
        S_PUT
    } ctrl_state_t;

    // Multiply-divide unit sequencer
    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_LOAD,
        A_DIV,
        A_FIN
    } arith_state_t;

    // Operands handed to an interpolation unit
    typedef struct packed {
        logic             start;
        logic [VelW-1:0]  v0;
        logic [VelW-1:0]  v1;
        logic [TimeW-1:0] dt;
        logic [TimeW-1:0] span;
    } arith_req_t;

    // Result from an interpolation unit
    typedef struct packed {
        logic            done;
        logic [VelW-1:0] value;
    } arith_rsp_t;

endpackage

@@ rtl/tli_ram.sv @@
// Generic simple dual-port RAM with registered read.
module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tli_arith.sv @@
// Iterative interpolation unit: v0 + round(|v1-v0|*dt/span) with sign, saturated.
module tli_arith (
    input  logic                aclk,
    input  logic                aresetn,
    input  tli_pkg::arith_req_t req,
    output tli_pkg::arith_rsp_t rsp
);

    localparam int VW = tli_pkg::VelW;
    localparam int TW = tli_pkg::TimeW;
    localparam int PW = VW + TW + 1;   // product plus rounding term
    localparam int QW = VW + 1;        // quotient never exceeds the magnitude

    tli_pkg::arith_state_t state_reg, state_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [VW-1:0] v0_reg, v0_next;
    logic          neg_reg, neg_next;
    logic [PW-1:0] mag_reg, mag_next;    // shifted multiplicand
    logic [TW-1:0] dt_reg, dt_next;      // multiplier, shifted right
    logic [TW-1:0] span_reg, span_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [TW-1:0] rem_reg, rem_next;
    logic [QW-1:0] sh_reg, sh_next;      // dividend bits still to shift in
    logic [QW-1:0] quo_reg, quo_next;
    logic [VW-1:0] res_reg, res_next;
    logic          done_reg, done_next;

    logic [VW:0]   diff;
    logic [TW:0]   trial;
    logic [VW+1:0] v0_ext, quo_ext, sum;

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tli_pkg::A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        v0_reg   <= v0_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        dt_reg   <= dt_next;
        span_reg <= span_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
    end

    // Shift-add multiply, then restoring divide, one bit per cycle
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        v0_next    = v0_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        dt_next    = dt_reg;
        span_next  = span_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        diff       = {req.v1[VW-1], req.v1} - {req.v0[VW-1], req.v0};
        trial      = {rem_reg, sh_reg[QW-1]};
        v0_ext     = {{2{v0_reg[VW-1]}}, v0_reg};
        quo_ext    = {1'b0, quo_reg};
        sum        = neg_reg ? (v0_ext - quo_ext) : (v0_ext + quo_ext);

        unique case (state_reg)
            tli_pkg::A_IDLE: begin
                if (req.start) begin
                    v0_next    = req.v0;
                    neg_next   = diff[VW];
                    mag_next   = diff[VW] ? PW'(VW'(-diff)) : PW'(diff[VW-1:0]);
                    dt_next    = req.dt;
                    span_next  = req.span;
                    // rounding term goes in first
                    acc_next   = PW'(req.span >> 1);
                    cnt_next   = '0;
                    state_next = tli_pkg::A_MUL;
                end
            end
            tli_pkg::A_MUL: begin
                if (dt_reg[0]) begin
                    acc_next = acc_reg + mag_reg;
                end
                mag_next = mag_reg << 1;
                dt_next  = dt_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(TW - 1)) begin
                    state_next = tli_pkg::A_LOAD;
                end
            end
            tli_pkg::A_LOAD: begin
                // upper part is below the divisor, so the quotient fits QW bits
                rem_next   = acc_reg[PW-1:QW];
                sh_next    = acc_reg[QW-1:0];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = tli_pkg::A_DIV;
            end
            tli_pkg::A_DIV: begin
                if (trial >= {1'b0, span_reg}) begin
                    rem_next = TW'(trial - {1'b0, span_reg});
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next = trial[TW-1:0];
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(QW - 1)) begin
                    state_next = tli_pkg::A_FIN;
                end
            end
            tli_pkg::A_FIN: begin
                // saturate to 32 bits
                if (sum[VW+1:VW-1] == 3'b000 || sum[VW+1:VW-1] == 3'b111) begin
                    res_next = sum[VW-1:0];
                end else if (!sum[VW+1]) begin
                    res_next = {1'b0, {(VW-1){1'b1}}};
                end else begin
                    res_next = {1'b1, {(VW-1){1'b0}}};
                end
                done_next  = 1'b1;
                state_next = tli_pkg::A_IDLE;
            end
            default: begin
                state_next = tli_pkg::A_IDLE;
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

@@ rtl/table_linear_interpolator.sv @@
// Table linear interpolator: a write word stores its entry and goes straight to the output
// stage; a query scans the stored times from entry 0, one entry per cycle through the
// table memory's read port, until the first time not below the query or the last valid
// entry, then runs the two bit-serial multiply-divide units (32 multiply, 33 divide steps)
// when interpolation is needed; one word is in work at a time, and a finished result sits
// in the output register while the next word is accepted.
module table_linear_interpolator #(
    parameter int ENTRIES = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, low to high: entry_index[11:0], entry_time[43:12], entry_vel_north[75:44],
    // entry_vel_east[107:76], query_time[139:108], zero pad[143:140]
    input  logic [143:0] s_tdata,
    input  logic [0:0]   s_tuser,   // kind
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // rate_east[31:0], rate_north[63:32]
    output logic [0:0]   m_tuser,   // status
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = $clog2(ENTRIES);
    localparam int VW = tli_pkg::VelW;
    localparam int TW = tli_pkg::TimeW;

    // Input fields
    logic                       in_kind;
    logic [tli_pkg::IndexW-1:0] in_index;
    tli_pkg::entry_t            in_entry;
    logic [TW-1:0]              in_query;
    logic                       s_fire;

    assign in_kind         = s_tuser[0];
    assign in_index        = s_tdata[11:0];
    assign in_entry.tstamp = s_tdata[43:12];
    assign in_entry.north  = s_tdata[75:44];
    assign in_entry.east   = s_tdata[107:76];
    assign in_query        = s_tdata[139:108];

    // Registers
    tli_pkg::ctrl_state_t     state_reg, state_next;
    logic [tli_pkg::CfgW-1:0] cfg_reg;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [TW-1:0]            query_reg, query_next;
    tli_pkg::entry_t          prev_reg, prev_next;
    logic [VW-1:0]            pend_east_reg, pend_east_next;
    logic [VW-1:0]            pend_north_reg, pend_north_next;
    logic                     pend_status_reg, pend_status_next;
    logic                     m_valid_reg, m_valid_next;
    logic [VW-1:0]            m_east_reg, m_east_next;
    logic [VW-1:0]            m_north_reg, m_north_next;
    logic                     m_status_reg, m_status_next;

    // Memory and units
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    tli_pkg::entry_t      cur;
    logic [TW-1:0]        last_idx;
    tli_pkg::arith_req_t  req_e, req_n;
    tli_pkg::arith_rsp_t  rsp_e, rsp_n;

    assign s_tready = (state_reg == tli_pkg::S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign ram_we   = s_fire && (in_kind == tli_pkg::KIND_WRITE)
                      && (TW'(in_index) < TW'(ENTRIES));

    tli_ram #(
        .WIDTH (tli_pkg::WordW),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(in_index)),
        .wdata (in_entry),
        .raddr (ram_raddr),
        .rdata (cur)
    );

    tli_arith u_east (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_e),
        .rsp     (rsp_e)
    );

    tli_arith u_north (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_n),
        .rsp     (rsp_n)
    );

    // Configuration port
    assign pready = 1'b1;
    assign prdata = 32'(cfg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= tli_pkg::CfgW'(4096);
        end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
            cfg_reg <= pwdata[tli_pkg::CfgW-1:0];
        end
    end

    // Last valid index, entry count clamped to [2, ENTRIES]
    always_comb begin
        if (TW'(cfg_reg) > TW'(ENTRIES)) begin
            last_idx = TW'(ENTRIES - 1);
        end else if (cfg_reg < tli_pkg::CfgW'(2)) begin
            last_idx = TW'(1);
        end else begin
            last_idx = TW'(cfg_reg) - TW'(1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tli_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        query_reg       <= query_next;
        prev_reg        <= prev_next;
        pend_east_reg   <= pend_east_next;
        pend_north_reg  <= pend_north_next;
        pend_status_reg <= pend_status_next;
        m_east_reg      <= m_east_next;
        m_north_reg     <= m_north_next;
        m_status_reg    <= m_status_next;
    end

    // Sequencer: scan, interpolate, hand result to the output register
    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        query_next       = query_reg;
        prev_next        = prev_reg;
        pend_east_next   = pend_east_reg;
        pend_north_next  = pend_north_reg;
        pend_status_next = pend_status_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_east_next      = m_east_reg;
        m_north_next     = m_north_reg;
        m_status_next    = m_status_reg;
        ram_raddr        = idx_reg + AW'(1);
        req_e            = '{start: 1'b0, v0: prev_reg.east, v1: cur.east,
                             dt: query_reg - prev_reg.tstamp,
                             span: cur.tstamp - prev_reg.tstamp};
        req_n            = '{start: 1'b0, v0: prev_reg.north, v1: cur.north,
                             dt: query_reg - prev_reg.tstamp,
                             span: cur.tstamp - prev_reg.tstamp};

        unique case (state_reg)
            tli_pkg::S_IDLE: begin
                ram_raddr = '0;
                if (s_fire) begin
                    idx_next         = '0;
                    query_next       = in_query;
                    pend_east_next   = '0;
                    pend_north_next  = '0;
                    pend_status_next = tli_pkg::STATUS_OK;
                    if (in_kind == tli_pkg::KIND_WRITE) begin
                        state_next = tli_pkg::S_PUT;
                    end else begin
                        state_next = tli_pkg::S_SCAN;
                    end
                end
            end
            tli_pkg::S_SCAN: begin
                // cur holds the entry at idx_reg
                if (cur.tstamp >= query_reg) begin
                    if (idx_reg == '0) begin
                        if (cur.tstamp == query_reg) begin
                            pend_east_next  = cur.east;
                            pend_north_next = cur.north;
                        end else begin
                            pend_status_next = tli_pkg::STATUS_RANGE;
                        end
                        state_next = tli_pkg::S_PUT;
                    end else begin
                        req_e.start = 1'b1;
                        req_n.start = 1'b1;
                        state_next  = tli_pkg::S_ARITH;
                    end
                end else if (TW'(idx_reg) == last_idx) begin
                    pend_status_next = tli_pkg::STATUS_RANGE;
                    state_next       = tli_pkg::S_PUT;
                end else begin
                    prev_next = cur;
                    idx_next  = idx_reg + AW'(1);
                end
            end
            tli_pkg::S_ARITH: begin
                // both units run in lockstep
                if (rsp_e.done && rsp_n.done) begin
                    pend_east_next  = rsp_e.value;
                    pend_north_next = rsp_n.value;
                    state_next      = tli_pkg::S_PUT;
                end
            end
            tli_pkg::S_PUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_east_next   = pend_east_reg;
                    m_north_next  = pend_north_reg;
                    m_status_next = pend_status_reg;
                    state_next    = tli_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tli_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_north_reg, m_east_reg};
    assign m_tuser  = m_status_reg;

endmodule

@@ tb/tb.sv @@
// Testbench for the table linear interpolator: stream stimulus, APB setup, predicted results.
module tb;
    import tli_pkg::*;

    localparam int NumEntries = 4096;
    localparam int CycleLimit = 3000000;
    localparam int IdlePct    = 11;

    typedef struct {
        logic [VelW-1:0] east;
        logic [VelW-1:0] north;
        logic            status;
    } rate_word_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [0:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Predictor copy of the table and the entry count register
    logic [TimeW-1:0] tbl_time  [NumEntries];
    logic [VelW-1:0]  tbl_north [NumEntries];
    logic [VelW-1:0]  tbl_east  [NumEntries];
    logic [CfgW-1:0]  cfg_entries;

    rate_word_t pending_rates[$];
    int         error_count;
    int         cycle_count;
    bit         idle_on;
    int         hold_cycles;

    table_linear_interpolator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Linear interpolation with magnitude rounded half away from zero, then saturated
    function automatic logic [VelW-1:0] lerp_velocity(logic [VelW-1:0] a, logic [VelW-1:0] b,
                                                      logic [TimeW-1:0] dt,
                                                      logic [TimeW-1:0] span);
        longint          v0;
        longint          v1;
        longint          diff;
        longint          res;
        longint unsigned mag;
        longint unsigned quot;
        v0   = longint'($signed(a));
        v1   = longint'($signed(b));
        diff = v1 - v0;
        mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
        quot = (mag * longint'({32'd0, dt}) + longint'({33'd0, span[31:1]}))
               / longint'({32'd0, span});
        res  = (diff < 0) ? v0 - longint'(quot) : v0 + longint'(quot);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[31:0];
    endfunction

    // Update the table or answer a query, as the block does for one accepted word
    function automatic rate_word_t predict_result(logic kind, logic [IndexW-1:0] idx,
                                                  logic [TimeW-1:0] t, logic [VelW-1:0] vn,
                                                  logic [VelW-1:0] ve, logic [TimeW-1:0] q);
        rate_word_t r;
        int         n;
        int         i;
        logic [TimeW-1:0] dt;
        logic [TimeW-1:0] span;
        r.east   = '0;
        r.north  = '0;
        r.status = STATUS_OK;
        if (kind == KIND_WRITE) begin
            tbl_time[idx]  = t;
            tbl_north[idx] = vn;
            tbl_east[idx]  = ve;
            return r;
        end
        n = cfg_entries;
        if (n < 2) n = 2;
        if (n > NumEntries) n = NumEntries;
        i = 0;
        while (i < n && tbl_time[i] < q) i++;
        if (i >= n || (i == 0 && tbl_time[0] != q)) begin
            r.status = STATUS_RANGE;
        end else if (i == 0) begin
            r.east  = tbl_east[0];
            r.north = tbl_north[0];
        end else begin
            dt      = q - tbl_time[i-1];
            span    = tbl_time[i] - tbl_time[i-1];
            r.east  = lerp_velocity(tbl_east[i-1], tbl_east[i], dt, span);
            r.north = lerp_velocity(tbl_north[i-1], tbl_north[i], dt, span);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %s: got %h, expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Result checker
    always @(posedge aclk) begin
        rate_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rates.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_rates.pop_front();
                if (m_tdata[31:0] !== want.east)
                    report_mismatch("rate_east", m_tdata[31:0], want.east);
                if (m_tdata[63:32] !== want.north)
                    report_mismatch("rate_north", m_tdata[63:32], want.north);
                if (m_tuser[0] !== want.status)
                    report_mismatch("status", {31'd0, m_tuser[0]}, {31'd0, want.status});
            end
        end
    end

    // Receiver: long hold-offs on request, random stalls otherwise
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                hold_cycles--;
            end else begin
                m_tready = !(idle_on && $urandom_range(99) < IdlePct);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("table_linear_interpolator: mismatch");
            $finish;
        end
    end

    task automatic send_word(logic kind, logic [IndexW-1:0] idx, logic [TimeW-1:0] t,
                             logic [VelW-1:0] vn, logic [VelW-1:0] ve, logic [TimeW-1:0] q);
        if (idle_on && $urandom_range(99) < IdlePct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {4'd0, q, ve, vn, t, idx};
        do @(posedge aclk); while (!s_tready);
        pending_rates.push_back(predict_result(kind, idx, t, vn, ve, q));
        @(negedge aclk);
    endtask

    task automatic write_entry(int idx, logic [31:0] t, logic [31:0] vn, logic [31:0] ve);
        send_word(KIND_WRITE, idx[IndexW-1:0], t, vn, ve, $urandom);
    endtask

    task automatic query_at(logic [31:0] q);
        send_word(KIND_QUERY, IndexW'($urandom), $urandom, $urandom, $urandom, q);
    endtask

    // Stop offering words and wait for every result, then the block's tail
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_rates.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    // APB write of entries_in_use, only while idle
    task automatic set_entries(int value);
        logic [31:0] word;
        word = {19'($urandom), value[CfgW-1:0]};
        drain();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = 1'b0;
        pwdata  = word;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        cfg_entries = word[CfgW-1:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [31:0] random_velocity();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    // Ascending table over entries 0..n-1 with random spacing
    task automatic fill_table(int n);
        logic [31:0] t;
        int          step_max;
        step_max = (32'h7FFF_FFFF / n);
        case ($urandom_range(2))
            0: step_max = 3;
            1: step_max = (step_max > 5000) ? 5000 : step_max;
            default: ;
        endcase
        t = $urandom_range(0, 32'h7FFF_FFFF);
        for (int i = 0; i < n; i++) begin
            write_entry(i, t, random_velocity(), random_velocity());
            t = t + $urandom_range(1, step_max);
        end
    endtask

    // Query time near the table: exact hits, inside a bracket, just outside, or anywhere
    function automatic logic [31:0] pick_query(int n);
        int j;
        j = $urandom_range(0, n - 1);
        case ($urandom_range(9))
            0, 1: return tbl_time[j];
            2: return tbl_time[0] - 1;
            3: return tbl_time[n-1] + 1;
            4: return $urandom;
            default: begin
                if (j == 0) return tbl_time[0];
                if (tbl_time[j] > tbl_time[j-1])
                    return tbl_time[j-1] + 1 + $urandom_range(0, tbl_time[j] - tbl_time[j-1] - 1);
                return tbl_time[j];
            end
        endcase
    endfunction

    // Directed: field extremes, exact first time, both range edges, span of one
    task automatic test_directed();
        set_entries(4);
        write_entry(0, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000);
        write_entry(1, 32'd200, 32'h8000_0000, 32'h7FFF_FFFF);
        write_entry(2, 32'd201, 32'h0001_0000, 32'hFFFF_0000);
        write_entry(3, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        query_at(32'd100);
        query_at(32'd99);
        query_at(32'd0);
        query_at(32'd150);
        query_at(32'd101);
        query_at(32'd199);
        query_at(32'd201);
        query_at(32'hFFFF_FFFE);
        query_at(32'hFFFF_FFFF);
        set_entries(3);
        query_at(32'hFFFF_FFFF);
        // descending times: the first-not-less scan still picks the bracket
        write_entry(1, 32'd50, 32'd7, 32'd9);
        query_at(32'd100);
        query_at(32'd101);
        // counts below two act as two
        set_entries(0);
        query_at(32'd100);
        query_at(32'd201);
        set_entries(1);
        query_at(32'd40);
    endtask

    // Counts at and above the table size; queries stop inside the written entries
    task automatic test_large_count();
        set_entries(8191);
        for (int i = 0; i < 64; i++)
            write_entry(i, i * 1000 + 7, random_velocity(), random_velocity());
        query_at(32'd7);
        query_at(32'd3);
        query_at(32'd63 * 1000 + 7);
        query_at(32'd40 * 1000 + 500);
        set_entries(4096);
        query_at(32'd20 * 1000 + 3);
        query_at(32'd62 * 1000 + 8);
    endtask

    // Random phases: fresh table per setting, then mixed writes and queries
    task automatic test_random();
        int n;
        for (int phase = 0; phase < 10; phase++) begin
            n = (phase == 0) ? 2 : (phase == 9) ? 200 : $urandom_range(2, 24);
            idle_on = (phase != 3);
            set_entries(n);
            fill_table(n);
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(99) < 20)
                    write_entry(($urandom_range(1) != 0) ? $urandom_range(0, n - 1)
                                                         : $urandom_range(0, NumEntries - 1),
                                $urandom, random_velocity(), random_velocity());
                else
                    query_at(pick_query(n));
            end
        end
        idle_on = 1'b1;
    endtask

    // Receiver holds off while queries keep coming; then a full pause before more
    task automatic test_backpressure();
        set_entries(8);
        fill_table(8);
        hold_cycles = 400;
        for (int k = 0; k < 20; k++) query_at(pick_query(8));
        drain();
        for (int k = 0; k < 10; k++) query_at(pick_query(8));
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cfg_entries = 13'd4096;
        error_count = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        hold_cycles = 0;
        for (int i = 0; i < NumEntries; i++) begin
            tbl_time[i]  = '0;
            tbl_north[i] = '0;
            tbl_east[i]  = '0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_large_count();
        test_random();
        test_backpressure();

        drain();
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("table_linear_interpolator: match");
        end else begin
            $display("table_linear_interpolator: mismatch");
        end
        $finish;
    end

endmodule
